// File: rtl/iso8601_utc_to_epoch_parser_defines.svh
// assertion macros for the checker file
`ifndef ISO8601_UTC_TO_EPOCH_PARSER_DEFINES_SVH
`define ISO8601_UTC_TO_EPOCH_PARSER_DEFINES_SVH

// same-cycle implication, sampled on the block clock, off during reset
`define ISO2EP_ASSERT_NOW(lbl, lhs, rhs) \
   lbl: assert property (@(posedge clock) disable iff (reset) (lhs) |-> (rhs)) \
      else $error("same-cycle check failed");

// next-cycle implication, sampled on the block clock, off during reset
`define ISO2EP_ASSERT_NEXT(lbl, lhs, rhs) \
   lbl: assert property (@(posedge clock) disable iff (reset) (lhs) |=> (rhs)) \
      else $error("next-cycle check failed");

`endif

// File: rtl/iso2ep_pkg.sv
// types, constants and tables for the timestamp to epoch parser
`timescale 1ns / 1ps

package iso2ep_pkg;

   // field widths
   localparam int CHAR_W   = 8;
   localparam int POS_W    = 5;
   localparam int YEAR_W   = 14;
   localparam int FIELD_W  = 7;
   localparam int EPOCH_W  = 39;
   localparam int RSP_W    = 40;
   localparam int OPA_W    = 22;
   localparam int OPB_W    = 17;
   localparam int SHYEAR_W = 15;
   localparam int DOY_W    = 9;
   localparam int QUO_W    = 7;
   localparam int QUO_LSB  = 19;

   // fixed part layout
   localparam logic [POS_W-1:0] FIXED_LAST = 5'd18;
   localparam logic [POS_W-1:0] FIXED_LEN  = 5'd19;

   // ascii codes
   localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2d;
   localparam logic [CHAR_W-1:0] CH_COLON = 8'h3a;
   localparam logic [CHAR_W-1:0] CH_T     = 8'h54;
   localparam logic [CHAR_W-1:0] CH_Z     = 8'h5a;
   localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2e;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;

   // arithmetic constants
   localparam logic [SHYEAR_W-1:0] YEAR_SHIFT   = 15'd400;
   localparam logic [OPB_W-1:0]    DAYS_YEAR    = 17'd365;
   localparam logic [OPB_W-1:0]    RECIP_100    = 17'd5243;
   localparam logic [OPB_W-1:0]    SEC_DAY      = 17'd86400;
   localparam logic [OPB_W-1:0]    SEC_HOUR     = 17'd3600;
   localparam logic [OPB_W-1:0]    SEC_MIN      = 17'd60;
   localparam logic [OPB_W-1:0]    UNIT         = 17'd1;
   // 719468 + 146097 for the 400 year shift, plus one for the day base
   localparam logic [OPA_W-1:0]    DAY_OFFSET   = 22'd865566;

   typedef enum logic [1:0] {
      PH_FIXED,
      PH_SEP,
      PH_FRAC,
      PH_ZED
   } phase_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_Y365,
      S_Q100,
      S_SUB100,
      S_Q400,
      S_ADD400,
      S_ADD4,
      S_DOY,
      S_DAYS,
      S_HOUR,
      S_MIN,
      S_SEC,
      S_OFF,
      S_DONE
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_ADD,
      OP_SUB,
      OP_QUOT
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [OPA_W-1:0] opa;
      logic [OPB_W-1:0] opb;
   } ctl_type;

   // days before the shifted month, year starting in march
   function automatic logic [DOY_W-1:0] cum_days(input logic [3:0] mp);
      logic [DOY_W-1:0] r;
      unique case (mp)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd31;
         4'd2:    r = 9'd61;
         4'd3:    r = 9'd92;
         4'd4:    r = 9'd122;
         4'd5:    r = 9'd153;
         4'd6:    r = 9'd184;
         4'd7:    r = 9'd214;
         4'd8:    r = 9'd245;
         4'd9:    r = 9'd275;
         4'd10:   r = 9'd306;
         4'd11:   r = 9'd337;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/iso8601_utc_to_epoch_parser.sv
// timestamp string parser with iterative epoch conversion
`timescale 1ns / 1ps

// channel   ports                        transfer contents
// --------  ---------------------------  ------------------------------------
// request   req_tvalid/tready/tdata/last one character, tlast marks string end
// response  rsp_tvalid/tready/tdata      valid flag and epoch seconds
//
// characters are taken while the sequencer is idle; after the last one a valid
// string steps the shared multiply-accumulate unit through S_Y365 to S_OFF and
// then loads the output register, an invalid one goes straight to the load;
// req_tready is low from the last character until the result is loaded
// a result waiting in the output register does not block the next string until
// its own last character; reset is synchronous and clears the parse state but
// not the ok flag

module iso8601_utc_to_epoch_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [iso2ep_pkg::CHAR_W-1:0]       req_tdata,  // char_byte
   input  logic                                req_tlast,  // last_char
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [iso2ep_pkg::RSP_W-1:0]        rsp_tdata   // valid_res, epoch_seconds
);

   // sequencer
   iso2ep_pkg::state_type state_ff, state_in;
   iso2ep_pkg::ctl_type   ctl;
   logic                  clear_parse;
   logic                  out_load;

   // parse state
   logic [iso2ep_pkg::POS_W-1:0]   pos_ff, pos_in;
   iso2ep_pkg::phase_type          phase_ff, phase_in;
   logic                           err_ff, err_in;
   logic [iso2ep_pkg::YEAR_W-1:0]  year_ff, year_in;
   logic [iso2ep_pkg::FIELD_W-1:0] mon_ff, mon_in;
   logic [iso2ep_pkg::FIELD_W-1:0] day_ff, day_in;
   logic [iso2ep_pkg::FIELD_W-1:0] hour_ff, hour_in;
   logic [iso2ep_pkg::FIELD_W-1:0] min_ff, min_in;
   logic [iso2ep_pkg::FIELD_W-1:0] sec_ff, sec_in;
   logic                           ok_ff, ok_in;

   // shared unit
   logic [iso2ep_pkg::EPOCH_W-1:0] acc_ff, acc_in;
   logic [iso2ep_pkg::QUO_W-1:0]   q_ff, q_in;
   logic [iso2ep_pkg::EPOCH_W-1:0] prod;

   // output register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_ok_ff, rsp_ok_in;
   logic [iso2ep_pkg::EPOCH_W-1:0] rsp_epoch_ff, rsp_epoch_in;

   logic                            accept;
   logic                            is_digit;
   logic [3:0]                      dig;
   logic [iso2ep_pkg::CHAR_W-1:0]   sep;
   logic [iso2ep_pkg::SHYEAR_W-1:0] shyear;
   logic [3:0]                      mshift;
   logic [iso2ep_pkg::DOY_W-1:0]    doyd;

   assign accept   = req_tvalid && req_tready;
   assign is_digit = (req_tdata >= iso2ep_pkg::CH_ZERO) && (req_tdata <= iso2ep_pkg::CH_NINE);
   assign dig      = req_tdata[3:0];

   // separator expected at a fixed position, none for digit positions
   always_comb begin
      unique case (pos_ff)
         5'd4, 5'd7:   sep = iso2ep_pkg::CH_DASH;
         5'd10:        sep = iso2ep_pkg::CH_T;
         5'd13, 5'd16: sep = iso2ep_pkg::CH_COLON;
         default:      sep = iso2ep_pkg::CH_NONE;
      endcase
   end

   // character parsing
   always_comb begin
      pos_in   = pos_ff;
      phase_in = phase_ff;
      err_in   = err_ff;
      year_in  = year_ff;
      mon_in   = mon_ff;
      day_in   = day_ff;
      hour_in  = hour_ff;
      min_in   = min_ff;
      sec_in   = sec_ff;
      if (clear_parse) begin
         pos_in   = '0;
         phase_in = iso2ep_pkg::PH_FIXED;
         err_in   = 1'b0;
         year_in  = '0;
         mon_in   = '0;
         day_in   = '0;
         hour_in  = '0;
         min_in   = '0;
         sec_in   = '0;
      end else if (accept) begin
         unique case (phase_ff)
            iso2ep_pkg::PH_FIXED: begin
               if (sep != iso2ep_pkg::CH_NONE) begin
                  if (req_tdata != sep) err_in = 1'b1;
               end else if (!is_digit) begin
                  err_in = 1'b1;
               end else begin
                  // acc * 10 + digit, wrapping at the field width
                  priority if (pos_ff < 5'd4) begin
                     year_in = 14'((year_ff << 3) + (year_ff << 1) + 14'(dig));
                  end else if (pos_ff < 5'd7) begin
                     mon_in = 7'((mon_ff << 3) + (mon_ff << 1) + 7'(dig));
                  end else if (pos_ff < 5'd10) begin
                     day_in = 7'((day_ff << 3) + (day_ff << 1) + 7'(dig));
                  end else if (pos_ff < 5'd13) begin
                     hour_in = 7'((hour_ff << 3) + (hour_ff << 1) + 7'(dig));
                  end else if (pos_ff < 5'd16) begin
                     min_in = 7'((min_ff << 3) + (min_ff << 1) + 7'(dig));
                  end else begin
                     sec_in = 7'((sec_ff << 3) + (sec_ff << 1) + 7'(dig));
                  end
               end
               if (pos_ff >= iso2ep_pkg::FIXED_LAST) begin
                  pos_in   = iso2ep_pkg::FIXED_LEN;
                  phase_in = iso2ep_pkg::PH_SEP;
               end else begin
                  pos_in = pos_ff + 5'd1;
               end
            end
            iso2ep_pkg::PH_SEP: begin
               priority if (req_tdata == iso2ep_pkg::CH_DOT) phase_in = iso2ep_pkg::PH_FRAC;
               else if (req_tdata == iso2ep_pkg::CH_Z) phase_in = iso2ep_pkg::PH_ZED;
               else err_in = 1'b1;
            end
            iso2ep_pkg::PH_FRAC: begin
               priority if (req_tdata == iso2ep_pkg::CH_Z) phase_in = iso2ep_pkg::PH_ZED;
               else if (!is_digit) err_in = 1'b1;
               else err_in = err_ff;  // fraction digit, nothing gathered
            end
            iso2ep_pkg::PH_ZED: begin
               // anything after the closing z
               err_in = 1'b1;
            end
            default: err_in = 1'b1;
         endcase
      end
   end

   // final shape and range check, taken on the last character
   always_comb begin
      ok_in = ok_ff;
      if (accept && req_tlast) begin
         ok_in = !err_in && (phase_in == iso2ep_pkg::PH_ZED) &&
                 (mon_in >= 7'd1) && (mon_in <= 7'd12) &&
                 (day_in >= 7'd1) && (day_in <= 7'd31) &&
                 (hour_in <= 7'd23) && (min_in <= 7'd59) && (sec_in <= 7'd60);
      end
   end

   // year shifted by 400 so it stays positive, minus one for january and february
   assign shyear = iso2ep_pkg::SHYEAR_W'(year_ff) + iso2ep_pkg::YEAR_SHIFT -
                   ((mon_ff <= 7'd2) ? 15'd1 : 15'd0);
   assign mshift = (mon_ff > 7'd2) ? 4'(mon_ff - 7'd3) : 4'(mon_ff + 7'd9);
   assign doyd   = iso2ep_pkg::cum_days(mshift) + iso2ep_pkg::DOY_W'(day_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         iso2ep_pkg::S_IDLE: begin
            if (accept && req_tlast) state_in = ok_in ? iso2ep_pkg::S_Y365 : iso2ep_pkg::S_DONE;
         end
         iso2ep_pkg::S_Y365:   state_in = iso2ep_pkg::S_Q100;
         iso2ep_pkg::S_Q100:   state_in = iso2ep_pkg::S_SUB100;
         iso2ep_pkg::S_SUB100: state_in = iso2ep_pkg::S_Q400;
         iso2ep_pkg::S_Q400:   state_in = iso2ep_pkg::S_ADD400;
         iso2ep_pkg::S_ADD400: state_in = iso2ep_pkg::S_ADD4;
         iso2ep_pkg::S_ADD4:   state_in = iso2ep_pkg::S_DOY;
         iso2ep_pkg::S_DOY:    state_in = iso2ep_pkg::S_DAYS;
         iso2ep_pkg::S_DAYS:   state_in = iso2ep_pkg::S_HOUR;
         iso2ep_pkg::S_HOUR:   state_in = iso2ep_pkg::S_MIN;
         iso2ep_pkg::S_MIN:    state_in = iso2ep_pkg::S_SEC;
         iso2ep_pkg::S_SEC:    state_in = iso2ep_pkg::S_OFF;
         iso2ep_pkg::S_OFF:    state_in = iso2ep_pkg::S_DONE;
         iso2ep_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) state_in = iso2ep_pkg::S_IDLE;
         end
         default: state_in = iso2ep_pkg::S_IDLE;
      endcase
   end

   // sequencer outputs: operands for the multiply-accumulate unit
   always_comb begin
      ctl         = '{op: iso2ep_pkg::OP_NONE, opa: '0, opb: '0};
      req_tready  = 1'b0;
      clear_parse = 1'b0;
      out_load    = 1'b0;
      unique case (state_ff)
         iso2ep_pkg::S_IDLE: req_tready = 1'b1;
         // days = Y*365 + Y/4 - Y/100 + Y/400 + doy
         iso2ep_pkg::S_Y365:
            ctl = '{iso2ep_pkg::OP_LOAD, iso2ep_pkg::OPA_W'(shyear), iso2ep_pkg::DAYS_YEAR};
         iso2ep_pkg::S_Q100:
            ctl = '{iso2ep_pkg::OP_QUOT, iso2ep_pkg::OPA_W'(shyear), iso2ep_pkg::RECIP_100};
         iso2ep_pkg::S_SUB100:
            ctl = '{iso2ep_pkg::OP_SUB, iso2ep_pkg::OPA_W'(q_ff), iso2ep_pkg::UNIT};
         iso2ep_pkg::S_Q400:
            ctl = '{iso2ep_pkg::OP_QUOT, iso2ep_pkg::OPA_W'(shyear >> 2), iso2ep_pkg::RECIP_100};
         iso2ep_pkg::S_ADD400:
            ctl = '{iso2ep_pkg::OP_ADD, iso2ep_pkg::OPA_W'(q_ff), iso2ep_pkg::UNIT};
         iso2ep_pkg::S_ADD4:
            ctl = '{iso2ep_pkg::OP_ADD, iso2ep_pkg::OPA_W'(shyear >> 2), iso2ep_pkg::UNIT};
         iso2ep_pkg::S_DOY:
            ctl = '{iso2ep_pkg::OP_ADD, iso2ep_pkg::OPA_W'(doyd), iso2ep_pkg::UNIT};
         // seconds, then the day base offset in seconds
         iso2ep_pkg::S_DAYS:
            ctl = '{iso2ep_pkg::OP_LOAD, acc_ff[iso2ep_pkg::OPA_W-1:0], iso2ep_pkg::SEC_DAY};
         iso2ep_pkg::S_HOUR:
            ctl = '{iso2ep_pkg::OP_ADD, iso2ep_pkg::OPA_W'(hour_ff), iso2ep_pkg::SEC_HOUR};
         iso2ep_pkg::S_MIN:
            ctl = '{iso2ep_pkg::OP_ADD, iso2ep_pkg::OPA_W'(min_ff), iso2ep_pkg::SEC_MIN};
         iso2ep_pkg::S_SEC:
            ctl = '{iso2ep_pkg::OP_ADD, iso2ep_pkg::OPA_W'(sec_ff), iso2ep_pkg::UNIT};
         iso2ep_pkg::S_OFF:
            ctl = '{iso2ep_pkg::OP_SUB, iso2ep_pkg::DAY_OFFSET, iso2ep_pkg::SEC_DAY};
         iso2ep_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load    = 1'b1;
               clear_parse = 1'b1;
            end
         end
         default: ctl = '{op: iso2ep_pkg::OP_NONE, opa: '0, opb: '0};
      endcase
   end

   // shared multiply-accumulate, operands zero extended to the full product width
   assign prod = {{iso2ep_pkg::OPB_W{1'b0}}, ctl.opa} * {{iso2ep_pkg::OPA_W{1'b0}}, ctl.opb};

   always_comb begin
      acc_in = acc_ff;
      q_in   = q_ff;
      unique case (ctl.op)
         iso2ep_pkg::OP_NONE: acc_in = acc_ff;
         iso2ep_pkg::OP_LOAD: acc_in = prod;
         iso2ep_pkg::OP_ADD:  acc_in = acc_ff + prod;
         iso2ep_pkg::OP_SUB:  acc_in = acc_ff - prod;
         iso2ep_pkg::OP_QUOT: q_in   = prod[iso2ep_pkg::QUO_LSB +: iso2ep_pkg::QUO_W];
         default:             acc_in = acc_ff;
      endcase
   end

   // output register, an invalid string reports zero seconds
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_epoch_in = rsp_epoch_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = ok_ff;
         rsp_epoch_in = ok_ff ? acc_ff : '0;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iso2ep_pkg::S_IDLE;
         pos_ff       <= '0;
         phase_ff     <= iso2ep_pkg::PH_FIXED;
         err_ff       <= 1'b0;
         year_ff      <= '0;
         mon_ff       <= '0;
         day_ff       <= '0;
         hour_ff      <= '0;
         min_ff       <= '0;
         sec_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         phase_ff     <= phase_in;
         err_ff       <= err_in;
         year_ff      <= year_in;
         mon_ff       <= mon_in;
         day_ff       <= day_in;
         hour_ff      <= hour_in;
         min_ff       <= min_in;
         sec_ff       <= sec_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff        <= ok_in;
      acc_ff       <= acc_in;
      q_ff         <= q_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_epoch_ff <= rsp_epoch_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_epoch_ff, rsp_ok_ff};

endmodule

// File: rtl/iso2ep_checker.sv
// port-level checks for the timestamp to epoch parser
`timescale 1ns / 1ps
`include "iso8601_utc_to_epoch_parser_defines.svh"

module iso2ep_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic                         req_tlast,  // last_char
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [iso2ep_pkg::RSP_W-1:0] rsp_tdata   // valid_res, epoch_seconds
);

   logic req_xfer;
   logic req_xfer_last;

   assign req_xfer      = req_tvalid && req_tready;
   assign req_xfer_last = req_xfer && req_tlast;

   // a rejected string always reports zero seconds
   `ISO2EP_ASSERT_NOW(a_invalid_zero, rsp_tvalid && !rsp_tdata[0],
                      rsp_tdata[iso2ep_pkg::RSP_W-1:1] == '0)

   // a stalled result holds
   `ISO2EP_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
                       rsp_tvalid && $stable(rsp_tdata))

   // the end of a string stops intake while the epoch is worked out
   `ISO2EP_ASSERT_NEXT(a_last_stalls, req_xfer_last, !req_tready)

   // inside a string the parser stays ready for the next character
   `ISO2EP_ASSERT_NEXT(a_mid_ready, req_xfer && !req_tlast, req_tready)

endmodule

bind iso8601_utc_to_epoch_parser iso2ep_checker u_iso2ep_checker (.*);

// File: tb/sv/iso8601_utc_to_epoch_parser_test.sv
// testbench for the timestamp string to epoch seconds parser, self-checking
`timescale 1ns / 1ps

module iso8601_utc_to_epoch_parser_test;
   import iso2ep_pkg::*;

   typedef struct {
      logic               ok;
      logic [EPOCH_W-1:0] secs;
   } epoch_result_t;

   typedef struct {
      string  text;
      bit     typed;
      logic   ok;
      longint secs;
   } stamp_row_t;

   typedef enum int {
      RDY_OPEN,
      RDY_RANDOM,
      RDY_HOLD
   } rdy_mode_t;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   wire                 req_tready;
   logic [CHAR_W-1:0]   req_tdata  = '0;   // char_byte
   logic                req_tlast  = 1'b0; // last_char
   wire                 rsp_tvalid;
   logic                rsp_tready = 1'b0;
   wire  [RSP_W-1:0]    rsp_tdata;         // valid_res, epoch_seconds

   iso8601_utc_to_epoch_parser DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // predictor state, mirrors the parse registers
   logic [POS_W-1:0]   ts_pos    = '0;
   phase_type          ts_phase  = PH_FIXED;
   logic               ts_bad    = 1'b0;
   logic [YEAR_W-1:0]  ts_year   = '0;
   logic [FIELD_W-1:0] ts_month  = '0;
   logic [FIELD_W-1:0] ts_day    = '0;
   logic [FIELD_W-1:0] ts_hour   = '0;
   logic [FIELD_W-1:0] ts_minute = '0;
   logic [FIELD_W-1:0] ts_second = '0;

   epoch_result_t epoch_due_q[$];
   stamp_row_t    stamp_rows[$];
   int            err_count    = 0;
   int            chars_sent   = 0;
   int            burst_left   = 0;

   // advances the parse by one character; returns 1 with the result on a last character
   function automatic bit parse_char(input logic [CHAR_W-1:0] c, input bit last,
                                     output epoch_result_t r);
      logic [CHAR_W-1:0] sep;
      bit                digit;
      bit                ok;
      int                d;
      longint            y, m, dd, era, yoe, doy, doe, days;
      digit = (c >= CH_ZERO) && (c <= CH_NINE);
      d     = int'(c) - int'(CH_ZERO);
      r.ok   = 1'b0;
      r.secs = '0;
      case (ts_phase)
         PH_FIXED: begin
            case (ts_pos)
               5'd4, 5'd7:   sep = CH_DASH;
               5'd10:        sep = CH_T;
               5'd13, 5'd16: sep = CH_COLON;
               default:      sep = CH_NONE;
            endcase
            if (sep != CH_NONE) begin
               if (c != sep) ts_bad = 1'b1;
            end else if (!digit) begin
               ts_bad = 1'b1;
            end else if (ts_pos < 4) begin
               ts_year = YEAR_W'(ts_year * 10 + d);
            end else if (ts_pos < 7) begin
               ts_month = FIELD_W'(ts_month * 10 + d);
            end else if (ts_pos < 10) begin
               ts_day = FIELD_W'(ts_day * 10 + d);
            end else if (ts_pos < 13) begin
               ts_hour = FIELD_W'(ts_hour * 10 + d);
            end else if (ts_pos < 16) begin
               ts_minute = FIELD_W'(ts_minute * 10 + d);
            end else begin
               ts_second = FIELD_W'(ts_second * 10 + d);
            end
            if (ts_pos == FIXED_LAST) begin
               ts_pos   = FIXED_LEN;
               ts_phase = PH_SEP;
            end else begin
               ts_pos = ts_pos + 1'b1;
            end
         end
         PH_SEP: begin
            if (c == CH_DOT) ts_phase = PH_FRAC;
            else if (c == CH_Z) ts_phase = PH_ZED;
            else ts_bad = 1'b1;
         end
         PH_FRAC: begin
            if (c == CH_Z) ts_phase = PH_ZED;
            else if (!digit) ts_bad = 1'b1;
         end
         default: ts_bad = 1'b1;
      endcase
      if (!last) return 1'b0;
      ok = !ts_bad && ts_phase == PH_ZED && ts_month >= 1 && ts_month <= 12 &&
           ts_day >= 1 && ts_day <= 31 && ts_hour <= 23 && ts_minute <= 59 &&
           ts_second <= 60;
      r.ok = ok;
      if (ok) begin
         // days from civil, year taken to start in march
         y  = longint'(ts_year);
         m  = longint'(ts_month);
         dd = longint'(ts_day);
         if (m <= 2) y = y - 1;
         era  = (y >= 0 ? y : y - 399) / 400;
         yoe  = y - era * 400;
         doy  = (153 * (m + (m > 2 ? -3 : 9)) + 2) / 5 + dd - 1;
         doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
         days = era * 146097 + doe - 719468;
         r.secs = EPOCH_W'(days * 86400 + longint'(ts_hour) * 3600
                           + longint'(ts_minute) * 60 + longint'(ts_second));
      end
      ts_pos    = '0;
      ts_phase  = PH_FIXED;
      ts_bad    = 1'b0;
      ts_year   = '0;
      ts_month  = '0;
      ts_day    = '0;
      ts_hour   = '0;
      ts_minute = '0;
      ts_second = '0;
      return 1'b1;
   endfunction

   task automatic add_row(input string text, input bit typed, input logic ok,
                          input longint secs);
      stamp_row_t row;
      row.text  = text;
      row.typed = typed;
      row.ok    = ok;
      row.secs  = secs;
      stamp_rows.insert(stamp_rows.size(), row);
   endtask

   // sends one string in bursts; a typed row replaces the predicted result
   task automatic send_string(input logic [CHAR_W-1:0] chars[$], input bit typed,
                              input logic ok, input longint secs);
      epoch_result_t r;
      int            gap;
      bit            last;
      foreach (chars[i]) begin
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 25);
         end
         burst_left--;
         last = (i == chars.size() - 1);
         req_tvalid <= 1'b1;
         req_tdata  <= chars[i];
         req_tlast  <= last;
         do @(posedge clock); while (!req_tready);
         if (parse_char(chars[i], last, r)) begin
            if (typed) begin
               r.ok   = ok;
               r.secs = secs[EPOCH_W-1:0];
            end
            epoch_due_q.insert(epoch_due_q.size(), r);
         end
         chars_sent++;
      end
   endtask

   // receiver: open, random and held spans of its own
   rdy_mode_t rdy_mode = RDY_OPEN;
   int        rdy_span = 0;
   always @(posedge clock) begin
      if (rdy_span == 0) begin
         rdy_mode = rdy_mode_t'($urandom_range(0, 2));
         rdy_span = (rdy_mode == RDY_HOLD) ? $urandom_range(1, 20) : $urandom_range(4, 60);
      end
      rdy_span--;
      rsp_tready <= (rdy_mode == RDY_OPEN) ||
                    (rdy_mode == RDY_RANDOM && $urandom_range(0, 1) == 1);
   end

   always @(posedge clock) begin : rsp_check
      epoch_result_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (epoch_due_q.size() == 0) begin
            $error("result transfer with nothing expected, tdata %h", rsp_tdata);
            err_count++;
         end else begin
            want = epoch_due_q.pop_front();
            if (rsp_tdata[0] !== want.ok) begin
               $error("valid_res expected %0d actual %0d", want.ok, rsp_tdata[0]);
               err_count++;
            end
            if (rsp_tdata[RSP_W-1:1] !== want.secs) begin
               $error("epoch_seconds expected %0d actual %0d", $signed(want.secs),
                      $signed(rsp_tdata[RSP_W-1:1]));
               err_count++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      logic [CHAR_W-1:0] chars[$];
      string             s;
      int                kind, yr, mo, dy, hr, mi, se, nfrac, cut;

      // directed rows: typed where the answer is obvious, predicted otherwise
      add_row("1970-01-01T00:00:00Z", 1, 1'b1, 0);
      add_row("0000-01-01T00:00:00Z", 1, 1'b1, -64'sd62167219200);
      add_row("9999-12-31T23:59:60Z", 1, 1'b1, 64'sd253402300800);
      add_row("0000-02-29T00:00:00Z", 0, 1'b0, 0);
      add_row("0000-03-01T00:00:00Z", 0, 1'b0, 0);
      add_row("2000-02-29T12:34:56.789Z", 0, 1'b0, 0);
      add_row("2000-01-01T00:00:00.Z", 0, 1'b0, 0);
      add_row("2021-06-15T08:30:45.1234567890123456789012345678901234567890Z",
              0, 1'b0, 0);
      add_row("2023-12-31T23:59:59Z", 0, 1'b0, 0);
      add_row("1970-01-01T00:00:00", 1, 1'b0, 0);       // short, no closing z
      add_row("Z", 1, 1'b0, 0);
      add_row("1970-01-01T00:00:00.123", 1, 1'b0, 0);   // fraction without z
      add_row("1970-01-01T00:00:00ZZ", 1, 1'b0, 0);     // char after z
      add_row("1970-01-01X00:00:00Z", 1, 1'b0, 0);      // bad separator
      add_row("19a0-01-01T00:00:00Z", 1, 1'b0, 0);      // bad digit
      add_row("1970-01-01T00:00:00X", 1, 1'b0, 0);
      add_row("1970-01-01T00:00:00.1a2Z", 1, 1'b0, 0);
      add_row("1970-00-01T00:00:00Z", 1, 1'b0, 0);
      add_row("1970-13-01T00:00:00Z", 1, 1'b0, 0);
      add_row("1970-01-00T00:00:00Z", 1, 1'b0, 0);
      add_row("1970-01-32T00:00:00Z", 1, 1'b0, 0);
      add_row("1970-01-01T24:00:00Z", 1, 1'b0, 0);
      add_row("1970-01-01T00:60:00Z", 1, 1'b0, 0);
      add_row("1970-01-01T00:00:61Z", 1, 1'b0, 0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stamp_rows[r]) begin
         chars = {};
         for (int i = 0; i < stamp_rows[r].text.len(); i++)
            chars.insert(chars.size(), stamp_rows[r].text[i]);
         send_string(chars, stamp_rows[r].typed, stamp_rows[r].ok, stamp_rows[r].secs);
      end

      // random strings: mostly well formed, some corrupted, some plain noise
      while (chars_sent < 1200) begin
         kind = $urandom_range(0, 99);
         yr = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 9999 : 0)
                                          : $urandom_range(0, 9999);
         mo = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
         dy = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 31);
         hr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23);
         mi = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
         se = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 60);
         s = $sformatf("%04d-%02d-%02dT%02d:%02d:%02d", yr, mo, dy, hr, mi, se);
         chars = {};
         for (int i = 0; i < s.len(); i++) chars.insert(chars.size(), s[i]);
         case ($urandom_range(0, 3))
            2: nfrac = $urandom_range(0, 6);
            3: nfrac = $urandom_range(0, 40);
            default: nfrac = -1;
         endcase
         if (nfrac >= 0) begin
            chars.insert(chars.size(), CH_DOT);
            repeat (nfrac)
               chars.insert(chars.size(), CHAR_W'(CH_ZERO + $urandom_range(0, 9)));
         end
         chars.insert(chars.size(), CH_Z);
         if (kind >= 90) begin
            chars = {};
            repeat ($urandom_range(1, 30))
               chars.insert(chars.size(), CHAR_W'($urandom_range(0, 255)));
         end else if (kind >= 85) begin
            repeat ($urandom_range(1, 3))
               chars.insert(chars.size(), CHAR_W'($urandom_range(0, 255)));
         end else if (kind >= 80) begin
            cut = $urandom_range(0, chars.size() - 2);
            chars = chars[0:cut];
         end else if (kind >= 70) begin
            chars[$urandom_range(0, chars.size() - 1)] = CHAR_W'($urandom_range(0, 255));
         end
         send_string(chars, 0, 1'b0, 0);
      end

      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
      while (epoch_due_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (err_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/iso2ep_pkg.sv
rtl/iso8601_utc_to_epoch_parser.sv
rtl/iso2ep_checker.sv
tb/sv/iso8601_utc_to_epoch_parser_test.sv
